// ----- hw/rtl/rbsct_pkg.sv -----
package rbsct_pkg;

   // default geometry
   localparam int SLOT_COUNT_DEF = 15;
   localparam int BANK_BYTES_DEF = 65536;

   // field widths
   localparam int ADDR_W   = 32;
   localparam int SEG_W    = 5;
   localparam int LEN_W    = 17;
   localparam int ACTION_W = 2;
   localparam int CSR_IDX_W = 8;

   // packed beat widths
   localparam int REQ_DATA_W = 72;   // 71 bits of fields, padded to whole bytes
   localparam int RSP_DATA_W = 120;  // 113 bits of fields, padded to whole bytes

   // request kinds
   localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UNMAP = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_WB    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_INV   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BASE   = 8'd3;

   typedef struct packed {
      logic              enabled;
      logic [ADDR_W-1:0] rom_window_start;
      logic [ADDR_W-1:0] rom_window_end;
      logic [ADDR_W-1:0] slot_area_base;
   } cfg_type;

   // tag store write / clear control
   typedef struct packed {
      logic              wr_en;
      logic              clr_all;
      logic [ADDR_W-1:0] data;
   } tag_wr_type;

endpackage

// ----- hw/rtl/rbsct_csr.sv -----
module rbsct_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rbsct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbsct_pkg::ADDR_W-1:0]        csr_data,
   output rbsct_pkg::cfg_type                  cfg
);

   rbsct_pkg::cfg_type cfg_ff;
   rbsct_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rbsct_pkg::CSR_ENABLED:      cfg_in.enabled          = csr_data[0];
            rbsct_pkg::CSR_WINDOW_START: cfg_in.rom_window_start = csr_data;
            rbsct_pkg::CSR_WINDOW_END:   cfg_in.rom_window_end   = csr_data;
            rbsct_pkg::CSR_SLOT_BASE:    cfg_in.slot_area_base   = csr_data;
            default: ;  // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/rbsct_tag_store.sv -----
module rbsct_tag_store #(
   parameter int SLOT_COUNT = rbsct_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [SLOT_W-1:0]              rd_slot,
   input  rbsct_pkg::tag_wr_type          wr,
   input  logic [SLOT_W-1:0]              wr_slot,
   output logic [rbsct_pkg::ADDR_W-1:0]   rd_tag
);

   logic [rbsct_pkg::ADDR_W-1:0] mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]        valid_ff;
   logic [SLOT_COUNT-1:0]        valid_in;

   logic [rbsct_pkg::ADDR_W-1:0] mem_rd_ff;
   logic                         vld_rd_ff;
   logic                         fwd_hit_ff;
   logic                         fwd_hit_in;
   logic [rbsct_pkg::ADDR_W-1:0] fwd_data_ff;
   logic [rbsct_pkg::ADDR_W-1:0] fwd_data_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr.clr_all) begin
         valid_in = '0;
      end else if (wr.wr_en) begin
         valid_in[wr_slot] = 1'b1;
      end
   end

   // a write landing on the same edge as the read is passed straight across
   assign fwd_hit_in  = wr.clr_all || (wr.wr_en && (wr_slot == rd_slot));
   assign fwd_data_in = wr.clr_all ? '0 : wr.data;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr_slot] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_slot];
         fwd_data_ff <= fwd_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         vld_rd_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            vld_rd_ff  <= valid_ff[rd_slot];
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   assign rd_tag = fwd_hit_ff ? fwd_data_ff : (vld_rd_ff ? mem_rd_ff : '0);

endmodule

// ----- hw/rtl/rom_bank_slot_cache_tags.sv -----
// An accepted request beat is registered in the work stage and then in the response register.
// Throughput: one request per cycle unless the response stalls; the tag memory is read at
//   acceptance and written as the beat leaves; back-to-back beats on one slot use a bypass.
// A stalled response holds the single work stage; the request side still takes a beat
//   while the response register waits, as long as the work stage is free.
// Reset: valid flags and config to zero, tag valid flops cleared at once (no clearing pass).
module rom_bank_slot_cache_tags #(
   parameter int SLOT_COUNT = rbsct_pkg::SLOT_COUNT_DEF,
   parameter int BANK_BYTES = rbsct_pkg::BANK_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: tdata = segment[4:0], source_address[36:5], byte_offset[53:37],
   //          byte_count[70:54], pad[71]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rbsct_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [rbsct_pkg::ACTION_W-1:0]       req_tuser,   // action[1:0]
   // response: tdata = mapped_address[31:0], copy_from[63:32], copy_to[95:64],
   //           copy_length[112:96], pad[119:113]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rbsct_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,   // copy_request
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rbsct_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbsct_pkg::ADDR_W-1:0]         csr_data
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int AW     = rbsct_pkg::ADDR_W;
   localparam int LW     = rbsct_pkg::LEN_W;
   localparam int SW     = rbsct_pkg::SEG_W;
   localparam logic [SW-1:0] SEG_MAX  = SW'(SLOT_COUNT);
   localparam logic [LW-1:0] BANK_LEN = LW'(BANK_BYTES);
   localparam logic [AW-1:0] BANK_A   = AW'(BANK_BYTES);

   rbsct_pkg::cfg_type cfg;

   // request fields
   logic [SW-1:0] req_seg;
   logic [AW-1:0] req_src;
   logic [LW-1:0] req_off;
   logic [LW-1:0] req_cnt;
   logic          req_acc;

   assign req_seg = req_tdata[4:0];
   assign req_src = req_tdata[36:5];
   assign req_off = req_tdata[53:37];
   assign req_cnt = req_tdata[70:54];

   // front checks, done while the tag is being read
   logic              seg_ok;
   logic [SW-1:0]     seg_m1;
   logic [SLOT_W-1:0] rd_slot;
   logic              map_ok;
   logic              wb_ok;
   logic [AW-1:0]     slot_addr;

   // work stage
   logic                           s1_valid_ff;
   logic [rbsct_pkg::ACTION_W-1:0] s1_action_ff;
   logic [AW-1:0]                  s1_src_ff;
   logic [LW-1:0]                  s1_off_ff;
   logic [LW-1:0]                  s1_cnt_ff;
   logic [SLOT_W-1:0]              s1_slot_ff;
   logic                           s1_seg_ok_ff;
   logic                           s1_map_ok_ff;
   logic                           s1_wb_ok_ff;
   logic [AW-1:0]                  s1_slot_addr_ff;
   logic                           s1_go;

   logic [AW-1:0] tag;

   // response register
   logic                             rsp_valid_ff;
   logic                             rsp_copy_ff;
   logic                             rsp_copy_in;
   logic [rbsct_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [rbsct_pkg::RSP_DATA_W-1:0] rsp_data_in;

   logic [AW-1:0] mapped_in;
   logic [AW-1:0] from_in;
   logic [AW-1:0] to_in;
   logic [LW-1:0] len_in;

   rbsct_pkg::tag_wr_type wr_calc;
   rbsct_pkg::tag_wr_type wr;

   rbsct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------
   // Handshake: the work stage drains whenever the response register
   // is empty or being emptied; a new beat enters behind it.
   // ---------------------------------------------------------------
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_acc    = req_tvalid && req_tready;

   // ---------------------------------------------------------------
   // Accept-side checks (none of these need the tag)
   // ---------------------------------------------------------------
   assign seg_ok  = (req_seg != '0) && (req_seg <= SEG_MAX);
   assign seg_m1  = req_seg - SW'(1);
   assign rd_slot = seg_ok ? SLOT_W'(seg_m1) : '0;

   assign map_ok = cfg.enabled && seg_ok
                   && (req_src >= cfg.rom_window_start)
                   && (req_src <= cfg.rom_window_end)
                   && ((cfg.rom_window_end - req_src) >= BANK_A);

   assign wb_ok  = cfg.enabled && seg_ok
                   && (req_off <= BANK_LEN)
                   && (req_cnt <= (BANK_LEN - req_off));

   // slot base: small constant multiply, registered before use
   assign slot_addr = cfg.slot_area_base + (AW'(seg_m1) * BANK_A);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_action_ff    <= req_tuser;
         s1_src_ff       <= req_src;
         s1_off_ff       <= req_off;
         s1_cnt_ff       <= req_cnt;
         s1_slot_ff      <= rd_slot;
         s1_seg_ok_ff    <= seg_ok;
         s1_map_ok_ff    <= map_ok;
         s1_wb_ok_ff     <= wb_ok;
         s1_slot_addr_ff <= slot_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   rbsct_tag_store #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_W     (SLOT_W)
   ) u_tags (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_slot (rd_slot),
      .wr      (wr),
      .wr_slot (s1_slot_ff),
      .rd_tag  (tag)
   );

   // ---------------------------------------------------------------
   // Work stage: tag compare, copy command and tag update
   // ---------------------------------------------------------------
   always_comb begin
      mapped_in   = '0;
      rsp_copy_in = 1'b0;
      from_in     = '0;
      to_in       = '0;
      len_in      = '0;
      wr_calc     = '0;
      unique case (s1_action_ff)
         rbsct_pkg::ACT_MAP: begin
            mapped_in = s1_src_ff;
            if (s1_map_ok_ff) begin
               mapped_in = s1_slot_addr_ff;
               // miss: fill the whole bank; a zero source looks like a hit
               if (tag != s1_src_ff) begin
                  rsp_copy_in  = 1'b1;
                  from_in      = s1_src_ff;
                  to_in        = s1_slot_addr_ff;
                  len_in       = BANK_LEN;
                  wr_calc.wr_en = 1'b1;
                  wr_calc.data  = s1_src_ff;
               end
            end
         end
         rbsct_pkg::ACT_UNMAP: begin
            // works with the cache disabled too
            if (s1_seg_ok_ff) begin
               wr_calc.wr_en = 1'b1;
            end
         end
         rbsct_pkg::ACT_WB: begin
            if (s1_wb_ok_ff && (tag != '0)) begin
               rsp_copy_in = 1'b1;
               from_in     = s1_slot_addr_ff + AW'(s1_off_ff);
               to_in       = tag + AW'(s1_off_ff);
               len_in      = s1_cnt_ff;
            end
         end
         rbsct_pkg::ACT_INV: begin
            wr_calc.clr_all = 1'b1;
         end
         default: ;
      endcase
   end

   // tag store only changes when the beat leaves the work stage
   always_comb begin
      wr         = wr_calc;
      wr.wr_en   = wr_calc.wr_en && s1_go;
      wr.clr_all = wr_calc.clr_all && s1_go;
   end

   assign rsp_data_in = {7'd0, len_in, to_in, from_in, mapped_in};

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= rsp_data_in;
         rsp_copy_ff <= rsp_copy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_copy_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted request beat did not reach the work stage");

   a_stall_holds_stage : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_action_ff)
                                   && $stable(s1_slot_ff)))
      else $error("work stage changed while stalled");

   a_rsp_from_stage : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_go))
      else $error("response beat raised without a beat leaving the work stage");

   a_no_write_on_stall : assert property (@(posedge clock) disable iff (reset)
      (wr.wr_en || wr.clr_all) |-> (s1_valid_ff && (!rsp_valid_ff || rsp_tready)))
      else $error("tag store written while the response side is stalled");

endmodule
